// ===== design/fwh_pkg.sv =====
// shared types, widths and codes for the fixed-width histogram core
// no dependencies; imported by every module of the block
package fwh_pkg;

  localparam int NUM_BINS_DEF = 64;

  localparam int VAL_W     = 32;  // sample and range start
  localparam int WIDTH_W   = 31;  // bin width register
  localparam int USE_W     = 7;   // bins in use register
  localparam int BIN_W     = 6;   // bin number and bin select
  localparam int CNT_W     = 32;  // bin counter
  localparam int OP_W      = 2;
  localparam int ST_W      = 2;
  localparam int CFG_IDX_W = 2;
  localparam int STEP_W    = $clog2(VAL_W);

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_SAT   = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RANGE_START = 2'd0,
    REG_BIN_WIDTH   = 2'd1,
    REG_BINS_IN_USE = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_DIV,
    S_RD,
    S_UPD,
    S_CLEAR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic               start;
    logic [VAL_W-1:0]   dividend;
    logic [WIDTH_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] quot;
  } div_res_t;

endpackage

// ===== design/fwh_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
// depends on fwh_pkg
module fwh_div (
  input  logic             clk,
  input  logic             rst_n,
  input  fwh_pkg::div_req_t req,
  output fwh_pkg::div_res_t res
);
  import fwh_pkg::*;

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(VAL_W - 1);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [WIDTH_W-1:0] rem_r, rem_nxt;
  logic [VAL_W-1:0]   dvd_r, dvd_nxt;
  logic [WIDTH_W-1:0] dsr_r, dsr_nxt;
  logic [VAL_W-1:0]   trial;
  logic [VAL_W-1:0]   diff;
  logic               ge;

  // dividend shifts out at the top, quotient bits shift in at the bottom
  assign trial = {rem_r, dvd_r[VAL_W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign ge    = trial >= {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = '0;
      dvd_nxt  = req.dividend;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[WIDTH_W-1:0] : trial[WIDTH_W-1:0];
      dvd_nxt  = {dvd_r[VAL_W-2:0], ge};
      step_nxt = step_r + STEP_W'(1);
      if (step_r == STEP_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
  end

  assign res.done = done_r;
  assign res.quot = dvd_r;

endmodule

// ===== design/fwh_ram.sv =====
// bin counter memory, one write and one registered read per cycle
// depends on fwh_pkg for the counter width and the default depth
module fwh_ram #(
  parameter int DEPTH = fwh_pkg::NUM_BINS_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [AW-1:0]            wr_addr,
  input  logic [fwh_pkg::CNT_W-1:0] wr_data,
  input  logic                     rd_en,
  input  logic [AW-1:0]            rd_addr,
  output logic [fwh_pkg::CNT_W-1:0] rd_data
);
  import fwh_pkg::*;

  logic [CNT_W-1:0] mem [DEPTH];
  logic [CNT_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/fixed_width_histogram_core.sv =====
// equal-width bin histogram: add sample, read bin, clear all bins
// add: load, 32 serial divider steps, bin check, memory read, update; above the top bin the result
//   follows the bin check, below range start it skips the divider; read: memory read, update;
// clear: every bin written; one item at a time, next item taken as the block returns to idle
// synchronous active-low reset; a clearing pass over every bin follows
//   reset, with in_stall high throughout; config writes are taken at all times
// depends on fwh_pkg, fwh_div and fwh_ram
module fixed_width_histogram_core #(
  parameter int NUM_BINS = fwh_pkg::NUM_BINS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // item input
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [fwh_pkg::OP_W-1:0]     in_opcode,
  input  logic signed [fwh_pkg::VAL_W-1:0] in_sample_value,
  input  logic [fwh_pkg::BIN_W-1:0]    in_bin_select,
  // result output
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [fwh_pkg::BIN_W-1:0]    out_bin_number,
  output logic [fwh_pkg::CNT_W-1:0]    out_bin_total,
  output logic [fwh_pkg::ST_W-1:0]     out_status,
  // register writes
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [fwh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fwh_pkg::VAL_W-1:0]    cfg_data
);
  import fwh_pkg::*;

  localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam logic [AW-1:0]    SWEEP_LAST = AW'(NUM_BINS - 1);
  localparam logic [VAL_W-1:0] NB_VAL     = VAL_W'(NUM_BINS);
  localparam logic [CNT_W-1:0] CNT_MAX    = '1;

  // configuration registers
  logic signed [VAL_W-1:0] range_start_r;
  logic [WIDTH_W-1:0]      bin_width_r;
  logic [USE_W-1:0]        bins_in_use_r;

  // control
  state_t           state_r, state_nxt;
  logic [AW-1:0]    sweep_r, sweep_nxt;
  logic [AW-1:0]    addr_r, addr_nxt;
  logic             is_read_r, is_read_nxt;
  logic             out_valid_r, out_valid_nxt;

  // pending result and output register
  logic [BIN_W-1:0] bin_r, bin_nxt;
  logic [CNT_W-1:0] res_total_r, res_total_nxt;
  status_t          res_status_r, res_status_nxt;
  logic [BIN_W-1:0] out_bin_r, out_bin_nxt;
  logic [CNT_W-1:0] out_total_r, out_total_nxt;
  status_t          out_status_r, out_status_nxt;

  // datapath
  logic [VAL_W:0]     diff;
  logic [WIDTH_W-1:0] divisor;
  logic [VAL_W-1:0]   used;
  logic               sel_oob;
  div_req_t           div_req;
  div_res_t           div_res;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [CNT_W-1:0]   ram_wdata;
  logic               ram_re;
  logic [CNT_W-1:0]   ram_rdata;
  logic [CNT_W-1:0]   cnt_inc;

  // offset from range start, one bit wider so that a negative offset shows
  assign diff    = {in_sample_value[VAL_W-1], in_sample_value}
                 - {range_start_r[VAL_W-1], range_start_r};
  // zero width behaves as one
  assign divisor = (bin_width_r == '0) ? WIDTH_W'(1) : bin_width_r;
  // bins counted, limited to the built count
  assign used    = ({{(VAL_W-USE_W){1'b0}}, bins_in_use_r} > NB_VAL)
                 ? NB_VAL : {{(VAL_W-USE_W){1'b0}}, bins_in_use_r};
  assign sel_oob = {{(VAL_W-BIN_W){1'b0}}, in_bin_select} >= NB_VAL;
  assign cnt_inc = ram_rdata + CNT_W'(1);

  fwh_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .res   (div_res)
  );

  fwh_ram #(
    .DEPTH (NUM_BINS),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (addr_r),
    .rd_data (ram_rdata)
  );

  // register writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_start_r <= '0;
      bin_width_r   <= WIDTH_W'(1);
      bins_in_use_r <= USE_W'(64);
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_RANGE_START: range_start_r <= cfg_data;
        REG_BIN_WIDTH:   bin_width_r   <= cfg_data[WIDTH_W-1:0];
        REG_BINS_IN_USE: bins_in_use_r <= cfg_data[USE_W-1:0];
        default: ;
      endcase
    end
  end

  // a new item is taken only in idle
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    sweep_nxt      = sweep_r;
    addr_nxt       = addr_r;
    is_read_nxt    = is_read_r;
    bin_nxt        = bin_r;
    res_total_nxt  = res_total_r;
    res_status_nxt = res_status_r;
    out_bin_nxt    = out_bin_r;
    out_total_nxt  = out_total_r;
    out_status_nxt = out_status_r;
    // output register empties on a transfer
    out_valid_nxt  = out_valid_r && out_stall;
    div_req.start    = 1'b0;
    div_req.dividend = diff[VAL_W-1:0];
    div_req.divisor  = divisor;
    ram_we         = 1'b0;
    ram_waddr      = addr_r;
    ram_wdata      = '0;
    ram_re         = 1'b0;

    unique case (state_r)
      // clearing pass after reset, no result
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_r;
        if (sweep_r == SWEEP_LAST) begin
          sweep_nxt = '0;
          state_nxt = S_IDLE;
        end else begin
          sweep_nxt = sweep_r + AW'(1);
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          bin_nxt        = '0;
          res_total_nxt  = '0;
          res_status_nxt = ST_OK;
          unique case (op_t'(in_opcode))
            OP_ADD: begin
              if (diff[VAL_W]) begin
                // below range start
                res_status_nxt = ST_RANGE;
                state_nxt      = S_DONE;
              end else begin
                div_req.start = 1'b1;
                state_nxt     = S_DIV;
              end
            end
            OP_READ: begin
              bin_nxt = in_bin_select;
              if (sel_oob) begin
                res_status_nxt = ST_RANGE;
                state_nxt      = S_DONE;
              end else begin
                addr_nxt    = AW'(in_bin_select);
                is_read_nxt = 1'b1;
                state_nxt   = S_RD;
              end
            end
            OP_CLEAR: begin
              sweep_nxt = '0;
              state_nxt = S_CLEAR;
            end
            default: begin
              // unused opcode: all-zero result, nothing changes
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_DIV: begin
        if (div_res.done) begin
          if (div_res.quot >= used) begin
            // beyond the last bin counted
            res_status_nxt = ST_RANGE;
            state_nxt      = S_DONE;
          end else begin
            addr_nxt    = div_res.quot[AW-1:0];
            bin_nxt     = div_res.quot[BIN_W-1:0];
            is_read_nxt = 1'b0;
            state_nxt   = S_RD;
          end
        end
      end
      S_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        state_nxt = S_DONE;
        if (ram_rdata == CNT_MAX) begin
          // saturated counter stays where it is
          res_total_nxt  = CNT_MAX;
          res_status_nxt = ST_SAT;
        end else if (is_read_r) begin
          res_total_nxt  = ram_rdata;
          res_status_nxt = ST_OK;
        end else begin
          ram_we         = 1'b1;
          ram_wdata      = cnt_inc;
          res_total_nxt  = cnt_inc;
          res_status_nxt = ST_OK;
        end
      end
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_r;
        if (sweep_r == SWEEP_LAST) begin
          sweep_nxt = '0;
          state_nxt = S_DONE;
        end else begin
          sweep_nxt = sweep_r + AW'(1);
        end
      end
      S_DONE: begin
        // hand over once the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_bin_nxt    = bin_r;
          out_total_nxt  = res_total_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
      is_read_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      out_valid_r <= out_valid_nxt;
      is_read_r   <= is_read_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r       <= addr_nxt;
    bin_r        <= bin_nxt;
    res_total_r  <= res_total_nxt;
    res_status_r <= res_status_nxt;
    out_bin_r    <= out_bin_nxt;
    out_total_r  <= out_total_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_bin_number = out_bin_r;
  assign out_bin_total  = out_total_r;
  assign out_status     = out_status_r;

  // an accepted item always holds off the next one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second item taken while one is in progress");

  // the divider only finishes while an add is waiting on it
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> (state_r == S_DIV))
    else $error("divider result with no add in progress");

  // a new result appears only from the hand-over state
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !$past(out_valid)) |-> ($past(state_r) == S_DONE))
    else $error("result raised outside hand-over");

  // the counter memory is left alone while idle
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !ram_we)
    else $error("counter write while idle");

endmodule

// ===== bench/tb.sv =====
// self-checking bench for the fixed-width histogram core: directed table, then phased random
// traffic under several register settings, every result checked against the table or a local bin tracker
// depends on fwh_pkg and fixed_width_histogram_core
module tb;
  import fwh_pkg::*;

  localparam int N_BINS    = NUM_BINS_DEF;
  localparam int DIR_ROWS  = 21;
  localparam int N_PHASES  = 8;
  localparam int PH_ITEMS  = 115;
  // receiver hold-off lands in the middle of the third phase
  localparam int PRESS_AT  = DIR_ROWS + 2 * PH_ITEMS + PH_ITEMS / 2;
  localparam int HOLD_LEN  = 400;
  // fifth phase runs with no idling on either side
  localparam int CALM_LO   = DIR_ROWS + 4 * PH_ITEMS;
  localparam int CALM_HI   = CALM_LO + PH_ITEMS;
  localparam int DRAIN_CYC = 100;   // longer than a clear pass
  localparam int MAX_SHOWN = 30;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic [BIN_W-1:0] bin;
    logic [CNT_W-1:0] total;
    status_t          st;
  } bin_result_t;

  typedef struct {
    op_t              op;
    logic [VAL_W-1:0] val;
    logic [BIN_W-1:0] sel;
    bit               typed;   // expected result written into the row
    logic [BIN_W-1:0] bin;
    logic [CNT_W-1:0] total;
    status_t          st;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [OP_W-1:0]       in_opcode = '0;
  logic [VAL_W-1:0]      in_sample_value = '0;
  logic [BIN_W-1:0]      in_bin_select = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [BIN_W-1:0]      out_bin_number;
  logic [CNT_W-1:0]      out_bin_total;
  logic [ST_W-1:0]       out_status;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [VAL_W-1:0]      cfg_data = '0;

  // local copy of the block's registers and bin store
  logic signed [VAL_W-1:0] cur_start = '0;
  logic [WIDTH_W-1:0]      cur_width = 31'd1;
  logic [USE_W-1:0]        cur_used  = 7'd64;
  logic [CNT_W-1:0]        tally [N_BINS];

  bin_result_t pending_bins [$];
  int items_sent   = 0;
  int results_seen = 0;
  int field_errors = 0;
  int settings_run = 0;

  stim_row_t directed_rows [DIR_ROWS] = '{
    // freshly cleared store after reset
    '{OP_READ,  32'h0000_0000, 6'd0,  1'b1, 6'd0,  32'd0, ST_OK},
    '{OP_READ,  32'h0000_0000, 6'd63, 1'b1, 6'd63, 32'd0, ST_OK},
    // lowest and highest bin with reset settings
    '{OP_ADD,   32'h0000_0000, 6'd0,  1'b1, 6'd0,  32'd1, ST_OK},
    '{OP_ADD,   32'h0000_003F, 6'd0,  1'b1, 6'd63, 32'd1, ST_OK},
    // one past the top, below start, signed extremes
    '{OP_ADD,   32'h0000_0040, 6'd0,  1'b1, 6'd0,  32'd0, ST_RANGE},
    '{OP_ADD,   32'hFFFF_FFFF, 6'd0,  1'b1, 6'd0,  32'd0, ST_RANGE},
    '{OP_ADD,   32'h7FFF_FFFF, 6'd0,  1'b1, 6'd0,  32'd0, ST_RANGE},
    '{OP_ADD,   32'h8000_0000, 6'd0,  1'b1, 6'd0,  32'd0, ST_RANGE},
    '{OP_ADD,   32'h0000_0000, 6'd0,  1'b1, 6'd0,  32'd2, ST_OK},
    '{OP_READ,  32'h0000_0000, 6'd0,  1'b1, 6'd0,  32'd2, ST_OK},
    // unknown opcode returns zeros whatever the payload
    '{OP_NONE,  32'hFFFF_FFFF, 6'd63, 1'b1, 6'd0,  32'd0, ST_OK},
    '{OP_READ,  32'hFFFF_FFFF, 6'd63, 1'b1, 6'd63, 32'd1, ST_OK},
    '{OP_ADD,   32'h0000_003E, 6'd0,  1'b0, 6'd0,  32'd0, ST_OK},
    '{OP_ADD,   32'h0000_001F, 6'd0,  1'b0, 6'd0,  32'd0, ST_OK},
    '{OP_READ,  32'h0000_0000, 6'd62, 1'b0, 6'd0,  32'd0, ST_OK},
    // clear, then everything reads back zero
    '{OP_CLEAR, 32'h55AA_33CC, 6'd21, 1'b1, 6'd0,  32'd0, ST_OK},
    '{OP_READ,  32'h0000_0000, 6'd0,  1'b1, 6'd0,  32'd0, ST_OK},
    '{OP_READ,  32'h0000_0000, 6'd62, 1'b1, 6'd62, 32'd0, ST_OK},
    '{OP_ADD,   32'h0000_0005, 6'd0,  1'b1, 6'd5,  32'd1, ST_OK},
    '{OP_NONE,  32'h0000_0000, 6'd0,  1'b1, 6'd0,  32'd0, ST_OK},
    '{OP_READ,  32'h0000_0000, 6'd5,  1'b1, 6'd5,  32'd1, ST_OK}
  };

  fixed_width_histogram_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_sample_value (in_sample_value),
    .in_bin_select   (in_bin_select),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_bin_number  (out_bin_number),
    .out_bin_total   (out_bin_total),
    .out_status      (out_status),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #1 clk = ~clk;

  // bin tracker: works out one item's result and updates the local store
  function automatic bin_result_t bin_update(op_t op, logic [VAL_W-1:0] val,
                                             logic [BIN_W-1:0] sel);
    bin_result_t r;
    longint diff, w, used, idx;
    r.bin   = '0;
    r.total = '0;
    r.st    = ST_OK;
    case (op)
      OP_ADD: begin
        diff = longint'(signed'(val)) - longint'(cur_start);
        // zero width behaves as one, more bins than built count as all of them
        w    = (cur_width == '0) ? 64'sd1 : longint'(cur_width);
        used = (cur_used > N_BINS) ? longint'(N_BINS) : longint'(cur_used);
        if (diff < 0) begin
          r.st = ST_RANGE;
        end else begin
          idx = diff / w;
          if (idx >= used) begin
            r.st = ST_RANGE;
          end else if (tally[idx] == '1) begin
            // counter already full: stays put
            r.bin   = idx[BIN_W-1:0];
            r.total = '1;
            r.st    = ST_SAT;
          end else begin
            tally[idx] = tally[idx] + 1'b1;
            r.bin   = idx[BIN_W-1:0];
            r.total = tally[idx];
          end
        end
      end
      OP_READ: begin
        r.bin   = sel;
        r.total = tally[sel];
        if (tally[sel] == '1) r.st = ST_SAT;
      end
      OP_CLEAR: begin
        foreach (tally[i]) tally[i] = '0;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // sample value spread over the current bin range, its edges and the whole field
  function automatic logic [VAL_W-1:0] pick_sample();
    longint w, used, lo;
    int kind;
    w    = (cur_width == '0) ? 64'sd1 : longint'(cur_width);
    used = (cur_used > N_BINS) ? longint'(N_BINS) : longint'(cur_used);
    lo   = longint'(cur_start);
    kind = $urandom_range(9);
    case (kind)
      0: return $urandom;
      1: return 32'(lo - 1 - longint'($urandom_range(2)));
      2: return 32'(lo + w * used - 2 + longint'($urandom_range(3)));
      default: begin
        return 32'(lo + longint'($urandom_range(32'((used == 0) ? 0 : used - 1))) * w
                   + longint'($urandom_range(32'(w - 1))));
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (field_errors < MAX_SHOWN)
      $display("[%0t] result %0d: %s got 0x%08h want 0x%08h",
               $realtime, results_seen, what, got, want);
    field_errors++;
  endtask

  // one register write, mirrored once the transfer happens; caller lowers valid
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_RANGE_START: cur_start = data;
      REG_BIN_WIDTH:   cur_width = data[WIDTH_W-1:0];
      REG_BINS_IN_USE: cur_used  = data[USE_W-1:0];
      default: begin
      end
    endcase
    @(negedge clk);
  endtask

  // offer one item, wait for its transfer, queue what it should return
  task automatic send_item(op_t op, logic [VAL_W-1:0] val, logic [BIN_W-1:0] sel,
                           bit typed, bin_result_t want);
    bin_result_t pred;
    bit calm;
    calm = (items_sent >= CALM_LO) && (items_sent < CALM_HI);
    if (!calm) begin
      while ($urandom_range(99) < 37) begin
        in_valid = 1'b0;
        @(negedge clk);
      end
    end
    in_valid        = 1'b1;
    in_opcode       = op;
    in_sample_value = val;
    in_bin_select   = sel;
    do @(posedge clk); while (in_stall);
    pred = bin_update(op, val, sel);
    pending_bins.push_back(typed ? want : pred);
    items_sent++;
    @(negedge clk);
  endtask

  // block is idle once every queued result has come back
  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending_bins.size() != 0) @(negedge clk);
  endtask

  // receiver: random stall, one long hold-off, one stretch without idling
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && results_seen >= PRESS_AT) begin
        held      = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else if (results_seen >= CALM_LO && results_seen < CALM_HI) begin
        out_stall = 1'b0;
      end else begin
        out_stall = ($urandom_range(99) < 37);
      end
    end
  end

  // result checker: each transfer against the oldest expectation
  always @(posedge clk) begin
    bin_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_bins.size() == 0) begin
        report_mismatch("unexpected result, bin_total", out_bin_total, 32'd0);
      end else begin
        want = pending_bins.pop_front();
        if (out_bin_number !== want.bin)
          report_mismatch("bin_number", 32'(out_bin_number), 32'(want.bin));
        if (out_bin_total !== want.total)
          report_mismatch("bin_total", out_bin_total, want.total);
        if (out_status !== want.st)
          report_mismatch("status", 32'(out_status), 32'(want.st));
      end
      results_seen++;
    end
  end

  // stimulus
  initial begin
    bin_result_t want;
    logic [VAL_W-1:0] s, w, u;
    longint lo, top;
    int r;
    foreach (tally[i]) tally[i] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table under reset settings, held off by the clearing pass
    for (int k = 0; k < DIR_ROWS; k++) begin
      want.bin   = directed_rows[k].bin;
      want.total = directed_rows[k].total;
      want.st    = directed_rows[k].st;
      send_item(directed_rows[k].op, directed_rows[k].val, directed_rows[k].sel,
                directed_rows[k].typed, want);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: begin s = 32'd0;          w = 32'd1;          u = 32'd64;        end
        1: begin s = 32'h8000_0000;  w = 32'h7FFF_FFFF;  u = 32'd1;         end
        2: begin s = 32'h7FFF_FFFF;  w = 32'd1;          u = 32'd64;        end
        // zero width and too many bins, upper data bits set
        3: begin s = $urandom;       w = 32'h8000_0000;  u = 32'hFFFF_FF7F; end
        4: begin s = -32'sd1000;     w = 32'd37;         u = 32'd64;        end
        // no bins: every sample out of range
        5: begin s = $urandom;       w = $urandom_range(1, 1 << 26); u = 32'hFFFF_FF80; end
        // bins cover the whole signed range exactly
        6: begin s = 32'h8000_0000;  w = 32'h0400_0000;  u = 32'd64;        end
        default: begin
          s = $urandom;
          w = $urandom_range(1, 1000);
          u = $urandom_range(1, N_BINS);
        end
      endcase
      write_reg(REG_RANGE_START, s);
      write_reg(REG_BIN_WIDTH, w);
      write_reg(REG_BINS_IN_USE, u);
      if (ph == N_PHASES - 1) write_reg(REG_UNUSED, $urandom);
      cfg_valid = 1'b0;
      settings_run++;

      // both edges of the counted range first
      lo  = longint'(cur_start);
      top = lo + ((cur_width == '0) ? 64'sd1 : longint'(cur_width))
               * ((cur_used > N_BINS) ? longint'(N_BINS) : longint'(cur_used));
      send_item(OP_ADD, 32'(lo - 1), 6'($urandom), 1'b0, want);
      send_item(OP_ADD, 32'(lo), 6'($urandom), 1'b0, want);
      send_item(OP_ADD, 32'(top - 1), 6'($urandom), 1'b0, want);
      send_item(OP_ADD, 32'(top), 6'($urandom), 1'b0, want);

      for (int k = 4; k < PH_ITEMS; k++) begin
        r = $urandom_range(99);
        if (r < 68)
          send_item(OP_ADD, pick_sample(), 6'($urandom), 1'b0, want);
        else if (r < 80)
          send_item(OP_READ, $urandom, 6'($urandom_range(7)), 1'b0, want);
        else if (r < 92)
          send_item(OP_READ, $urandom, 6'($urandom), 1'b0, want);
        else if (r < 97)
          send_item(OP_NONE, $urandom, 6'($urandom), 1'b0, want);
        else
          send_item(OP_CLEAR, $urandom, 6'($urandom), 1'b0, want);
      end
    end

    wait_idle();
    repeat (DRAIN_CYC) @(posedge clk);
    $display("%0d items (%0d from the table) across %0d register settings, %0d results",
             items_sent, DIR_ROWS, settings_run, results_seen);
    $display("covered range edges, zero width, no bins, excess bins, clears, unknown ops");
    if (field_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
